### design/sqp_pkg.sv
// sqp_pkg: widths, constants and types shared by the quaternion packer
// no dependencies; imported by every sqp module and by the top level
`default_nettype none

package sqp_pkg;

    // input and component counts
    localparam int INPUT_BITS = 16;
    localparam int NUM_COMP   = 4;
    localparam int IDX_BITS   = 2;
    localparam int MAG_BITS   = INPUT_BITS;
    localparam int POS_BITS   = $clog2(INPUT_BITS);

    // normalised magnitudes: top bit lands at position NORM_TOP
    localparam int NORM_BITS  = 16;
    localparam int NORM_TOP   = NORM_BITS - 1;
    localparam int SQ_BITS    = 2 * NORM_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;

    // square root of sum * 2^28
    localparam int RAD_SHIFT  = 28;
    localparam int RAD_BITS   = SUM_BITS + RAD_SHIFT;
    localparam int ROOT_BITS  = RAD_BITS / 2;
    localparam int REM_BITS   = ROOT_BITS + 1;

    // division (r * 2^29 + L/2) / L
    localparam int NUM_SHIFT  = 29;
    localparam int NUM_BITS   = NORM_BITS + NUM_SHIFT + 1;
    localparam int QUO_BITS   = 17;
    localparam int N_BITS     = 15;

    // byte mapping
    localparam int GAIN_BITS  = 24;
    localparam logic [GAIN_BITS-1:0] SQRT2_GAIN = GAIN_BITS'(11816942);
    localparam int PROD_BITS  = GAIN_BITS + N_BITS;
    localparam int BYTE_SHIFT = 31;
    localparam logic [7:0] TAG_BASE  = 8'd252;
    localparam logic [7:0] BYTE_MID  = 8'd128;

    // cycles from an accepted item to its result strobe
    localparam int LAT_PREP   = 4;
    localparam int LAT_SQRT   = ROOT_BITS + 1;
    localparam int LAT_DIV    = QUO_BITS + 1;
    localparam int LAT_ENC    = 3;
    localparam int LATENCY    = LAT_PREP + LAT_SQRT + LAT_DIV + LAT_ENC;

    typedef logic [NORM_BITS-1:0] norm_t;
    typedef logic [QUO_BITS-1:0]  quo_t;

    // sideband carried with each item through the arithmetic stages
    typedef struct packed {
        norm_t [NUM_COMP-1:0]  r;
        logic  [NUM_COMP-1:0]  neg;
        logic                  zero;
    } meta_t;

endpackage

`default_nettype wire

### design/sqp_prep.sv
// sqp_prep: magnitudes, normalising shift, squares and sum of squares
// depends on sqp_pkg
`default_nettype none

module sqp_prep
    import sqp_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [NUM_COMP-1:0][INPUT_BITS-1:0] comp,
    output logic                               out_valid,
    output logic [SUM_BITS-1:0]                out_sum,
    output meta_t                              out_meta
);

    logic [NUM_COMP-1:0][MAG_BITS-1:0] mag_reg;
    logic [NUM_COMP-1:0]               neg_reg;
    logic [3:0]                        vld_reg;
    meta_t                             meta_b_reg, meta_c_reg, meta_d_reg;
    meta_t                             meta_b_next;
    logic [NUM_COMP-1:0][SQ_BITS-1:0]  sq_reg;
    logic [SUM_BITS-1:0]               sum_reg;
    logic [MAG_BITS-1:0]               mag_max;
    logic [POS_BITS-1:0]               top_pos;
    logic [MAG_BITS+NORM_BITS-1:0]     shifted;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // stage a: signs and magnitudes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            neg_reg[i] <= comp[i][INPUT_BITS-1];
            mag_reg[i] <= comp[i][INPUT_BITS-1] ? MAG_BITS'(~comp[i] + 1'b1) : comp[i];
        end
    end

    // largest magnitude, its top bit and the normalising shift
    always_comb
    begin
        mag_max = '0;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            if (mag_reg[i] > mag_max)
            begin
                mag_max = mag_reg[i];
            end
        end
        top_pos = '0;
        for (int b = 0; b < MAG_BITS; b++)
        begin
            if (mag_max[b])
            begin
                top_pos = POS_BITS'(b);
            end
        end
        meta_b_next.neg  = neg_reg;
        meta_b_next.zero = (mag_max == '0);
        for (int i = 0; i < NUM_COMP; i++)
        begin
            if (top_pos > POS_BITS'(NORM_TOP))
            begin
                shifted = (MAG_BITS+NORM_BITS)'(mag_reg[i])
                          >> (top_pos - POS_BITS'(NORM_TOP));
            end
            else
            begin
                shifted = (MAG_BITS+NORM_BITS)'(mag_reg[i])
                          << (POS_BITS'(NORM_TOP) - top_pos);
            end
            meta_b_next.r[i] = shifted[NORM_BITS-1:0];
        end
    end

    // stage b, c, d: normalised values, squares, sum
    always_ff @(posedge clk)
    begin
        meta_b_reg <= meta_b_next;
        meta_c_reg <= meta_b_reg;
        meta_d_reg <= meta_c_reg;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            sq_reg[i] <= SQ_BITS'(meta_b_reg.r[i]) * SQ_BITS'(meta_b_reg.r[i]);
        end
        sum_reg <= SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1])
                 + SUM_BITS'(sq_reg[2]) + SUM_BITS'(sq_reg[3]);
    end

    assign out_valid = vld_reg[3];
    assign out_sum   = sum_reg;
    assign out_meta  = meta_d_reg;

endmodule

`default_nettype wire

### design/sqp_sqrt.sv
// sqp_sqrt: pipelined integer square root of sum * 2^28, one root bit per stage
// depends on sqp_pkg
`default_nettype none

module sqp_sqrt
    import sqp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [SUM_BITS-1:0]  in_sum,
    input  wire meta_t                in_meta,
    output logic                      out_valid,
    output logic [ROOT_BITS-1:0]      out_root,
    output meta_t                     out_meta
);

    logic [ROOT_BITS:0]   vld_reg;
    logic [SUM_BITS-1:0]  sum_reg  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [0:ROOT_BITS];
    logic [REM_BITS-1:0]  rem_reg  [0:ROOT_BITS];
    meta_t                meta_reg [0:ROOT_BITS];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ROOT_BITS-1:0], in_valid};
        end
    end

    // entry register
    always_ff @(posedge clk)
    begin
        sum_reg[0]  <= in_sum;
        root_reg[0] <= '0;
        rem_reg[0]  <= '0;
        meta_reg[0] <= in_meta;
    end

    // one digit pair per stage
    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_step
        logic [RAD_BITS-1:0]  rad;
        logic [REM_BITS+1:0]  rem_sh;
        logic [REM_BITS+1:0]  trial;
        logic                 fits;
        logic [ROOT_BITS-1:0] root_next;
        logic [REM_BITS-1:0]  rem_next;

        always_comb
        begin
            rad       = {sum_reg[j], {RAD_SHIFT{1'b0}}};
            rem_sh    = {rem_reg[j], rad[RAD_BITS-1-2*j -: 2]};
            trial     = {1'b0, root_reg[j], 2'b01};
            fits      = (rem_sh >= trial);
            root_next = {root_reg[j][ROOT_BITS-2:0], fits};
            rem_next  = fits ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
        end

        always_ff @(posedge clk)
        begin
            sum_reg[j+1]  <= sum_reg[j];
            root_reg[j+1] <= root_next;
            rem_reg[j+1]  <= rem_next;
            meta_reg[j+1] <= meta_reg[j];
        end
    end

    assign out_valid = vld_reg[ROOT_BITS];
    assign out_root  = root_reg[ROOT_BITS];
    assign out_meta  = meta_reg[ROOT_BITS];

endmodule

`default_nettype wire

### design/sqp_div.sv
// sqp_div: four-lane pipelined restoring divider, one quotient bit per stage
// depends on sqp_pkg
`default_nettype none

module sqp_div
    import sqp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [ROOT_BITS-1:0]  in_root,
    input  wire meta_t                 in_meta,
    output logic                       out_valid,
    output quo_t [NUM_COMP-1:0]        out_quo,
    output meta_t                      out_meta
);

    logic [QUO_BITS:0]                  vld_reg;
    logic [ROOT_BITS-1:0]               den_reg [0:QUO_BITS];
    logic [NUM_COMP-1:0][ROOT_BITS-1:0] rem_reg [0:QUO_BITS];
    logic [NUM_COMP-1:0][QUO_BITS-1:0]  low_reg [0:QUO_BITS];
    quo_t [NUM_COMP-1:0]                quo_reg [0:QUO_BITS];
    meta_t                              meta_reg[0:QUO_BITS];
    logic [NUM_COMP-1:0][NUM_BITS-1:0]  num;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[QUO_BITS-1:0], in_valid};
        end
    end

    // numerators with the rounding half-divisor
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            num[i] = {1'b0, in_meta.r[i], {NUM_SHIFT{1'b0}}}
                   + NUM_BITS'(in_root >> 1);
        end
    end

    // entry register: top part as first remainder, low bits to shift in
    always_ff @(posedge clk)
    begin
        den_reg[0]  <= in_root;
        meta_reg[0] <= in_meta;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            rem_reg[0][i] <= ROOT_BITS'(num[i][NUM_BITS-1:QUO_BITS]);
            low_reg[0][i] <= num[i][QUO_BITS-1:0];
            quo_reg[0][i] <= '0;
        end
    end

    // one quotient bit per stage in each lane
    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_step
        logic [NUM_COMP-1:0][ROOT_BITS:0]   part;
        logic [NUM_COMP-1:0]                fits;
        logic [NUM_COMP-1:0][ROOT_BITS-1:0] rem_next;

        always_comb
        begin
            for (int i = 0; i < NUM_COMP; i++)
            begin
                part[i]     = {rem_reg[j][i], low_reg[j][i][QUO_BITS-1-j]};
                fits[i]     = (part[i] >= {1'b0, den_reg[j]});
                rem_next[i] = fits[i] ? ROOT_BITS'(part[i] - {1'b0, den_reg[j]})
                                      : ROOT_BITS'(part[i]);
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[j+1]  <= den_reg[j];
            meta_reg[j+1] <= meta_reg[j];
            low_reg[j+1]  <= low_reg[j];
            rem_reg[j+1]  <= rem_next;
            for (int i = 0; i < NUM_COMP; i++)
            begin
                quo_reg[j+1][i] <= {quo_reg[j][i][QUO_BITS-2:0], fits[i]};
            end
        end
    end

    assign out_valid = vld_reg[QUO_BITS];
    assign out_quo   = quo_reg[QUO_BITS];
    assign out_meta  = meta_reg[QUO_BITS];

endmodule

`default_nettype wire

### design/sqp_encode.sv
// sqp_encode: saturation, largest pick, sign fold, sqrt(2) gain and byte packing
// depends on sqp_pkg
`default_nettype none

module sqp_encode
    import sqp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire quo_t [NUM_COMP-1:0] in_quo,
    input  wire meta_t         in_meta,
    output logic               out_valid,
    output logic [7:0]         out_first,
    output logic [7:0]         out_second,
    output logic [7:0]         out_third,
    output logic [7:0]         out_tag
);

    logic [2:0]                          vld_reg;
    logic [NUM_COMP-1:0][N_BITS-1:0]     n_next, n_reg;
    logic [NUM_COMP-1:0]                 neg_next, neg_a_reg, neg_b_reg;
    logic [IDX_BITS-1:0]                 big_next, big_a_reg, big_b_reg;
    logic                                zero_a_reg, zero_b_reg;
    logic [NUM_COMP-1:0][PROD_BITS-1:0]  prod_reg;
    logic [NUM_COMP-1:0][7:0]            byte_val;
    logic [2:0][7:0]                     kept;
    logic [IDX_BITS-1:0]                 pick;
    logic [7:0]                          first_reg, second_reg, third_reg, tag_reg;

    // product to byte, rounding down (towards minus infinity) then saturating
    function automatic logic [7:0] to_byte(input logic [PROD_BITS-1:0] t, input logic neg);
        logic [PROD_BITS-1:0] q;
        logic [7:0]           r;
        if (!neg)
        begin
            q = t >> BYTE_SHIFT;
            r = (q >= PROD_BITS'(127)) ? 8'd255 : 8'(BYTE_MID + q[7:0]);
        end
        else
        begin
            q = (t + PROD_BITS'((64'd1 << BYTE_SHIFT) - 64'd1)) >> BYTE_SHIFT;
            r = (q >= PROD_BITS'(128)) ? 8'd0 : 8'(BYTE_MID - q[7:0]);
        end
        return r;
    endfunction

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // saturate, pick the first largest, fold signs
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            n_next[i] = (in_quo[i] > QUO_BITS'({N_BITS{1'b1}})) ? {N_BITS{1'b1}}
                                                                 : in_quo[i][N_BITS-1:0];
        end
        big_next = '0;
        for (int i = 1; i < NUM_COMP; i++)
        begin
            if (n_next[i] > n_next[big_next])
            begin
                big_next = IDX_BITS'(i);
            end
        end
        neg_next = in_meta.neg ^ {NUM_COMP{in_meta.neg[big_next]}};
    end

    // stage a and b: magnitudes, then gain products
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        neg_a_reg  <= neg_next;
        big_a_reg  <= big_next;
        zero_a_reg <= in_meta.zero;
        neg_b_reg  <= neg_a_reg;
        big_b_reg  <= big_a_reg;
        zero_b_reg <= zero_a_reg;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            prod_reg[i] <= PROD_BITS'(SQRT2_GAIN) * PROD_BITS'(n_reg[i]);
        end
    end

    // bytes and selection of the three kept components
    always_comb
    begin
        for (int i = 0; i < NUM_COMP; i++)
        begin
            byte_val[i] = to_byte(prod_reg[i], neg_b_reg[i]);
        end
        for (int k = 0; k < 3; k++)
        begin
            pick    = (IDX_BITS'(k) < big_b_reg) ? IDX_BITS'(k) : IDX_BITS'(k + 1);
            kept[k] = zero_b_reg ? BYTE_MID : byte_val[pick];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        first_reg  <= kept[0];
        second_reg <= kept[1];
        third_reg  <= kept[2];
        tag_reg    <= zero_b_reg ? TAG_BASE : 8'(TAG_BASE + 8'(big_b_reg));
    end

    assign out_valid  = vld_reg[2];
    assign out_first  = first_reg;
    assign out_second = second_reg;
    assign out_third  = third_reg;
    assign out_tag    = tag_reg;

endmodule

`default_nettype wire

### design/quaternion_smallest_three_packer_top.sv
// quaternion_smallest_three_packer_top: normalise, drop largest, pack three bytes
// depends on sqp_pkg, sqp_prep, sqp_sqrt, sqp_div, sqp_encode
//
//   channel   handshake        payload
//   input     start / busy     comp_zero, comp_one, comp_two, comp_three
//   result    done strobe      byte_first, byte_second, byte_third, tag_byte
//
// one item enters per cycle; busy stays low as nothing can stall the pipe
// each result comes with a one-cycle done strobe
// depth set by the square root (one root bit per stage) and the divider
// (one quotient bit per stage, four lanes side by side)
// reset clears only the valid chain; items in flight are dropped
`default_nettype none

module quaternion_smallest_three_packer_top
    import sqp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [INPUT_BITS-1:0]  comp_zero,
    input  wire logic [INPUT_BITS-1:0]  comp_one,
    input  wire logic [INPUT_BITS-1:0]  comp_two,
    input  wire logic [INPUT_BITS-1:0]  comp_three,
    output logic                        done,
    output logic [7:0]                  byte_first,
    output logic [7:0]                  byte_second,
    output logic [7:0]                  byte_third,
    output logic [7:0]                  tag_byte
);

    logic [NUM_COMP-1:0][INPUT_BITS-1:0] comp;
    logic                                prep_valid, sqrt_valid, div_valid;
    logic [SUM_BITS-1:0]                 prep_sum;
    logic [ROOT_BITS-1:0]                sqrt_root;
    meta_t                               prep_meta, sqrt_meta, div_meta;
    quo_t [NUM_COMP-1:0]                 div_quo;

    assign busy = 1'b0;
    assign comp = {comp_three, comp_two, comp_one, comp_zero};

    // front end: magnitudes and sum of squares
    sqp_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .comp      (comp),
        .out_valid (prep_valid),
        .out_sum   (prep_sum),
        .out_meta  (prep_meta)
    );

    // vector length
    sqp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_sum    (prep_sum),
        .in_meta   (prep_meta),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_meta  (sqrt_meta)
    );

    // unit-length components
    sqp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .in_root   (sqrt_root),
        .in_meta   (sqrt_meta),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_meta  (div_meta)
    );

    // byte packing
    sqp_encode u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_quo     (div_quo),
        .in_meta    (div_meta),
        .out_valid  (done),
        .out_first  (byte_first),
        .out_second (byte_second),
        .out_third  (byte_third),
        .out_tag    (tag_byte)
    );

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("item did not reach the output in time");

    a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tag_byte[7:2] == TAG_BASE[7:2]))
        else $error("tag byte out of range");

    a_zero_item: assert property (@(posedge clk) disable iff (!rst_n)
        (start && comp_zero == '0 && comp_one == '0 && comp_two == '0
         && comp_three == '0)
        |-> ##LATENCY (byte_first == BYTE_MID && byte_second == BYTE_MID
                       && byte_third == BYTE_MID && tag_byte == TAG_BASE))
        else $error("all-zero item packed wrongly");
`endif

endmodule

`default_nettype wire

### tb/quaternion_smallest_three_packer_top_test.sv
// testbench for quaternion_smallest_three_packer_top: random and directed quaternions
// depends on sqp_pkg and the packer rtl; self-checking against an internal predictor
`timescale 1ns / 1ps

module quaternion_smallest_three_packer_top_test
    import sqp_pkg::*;
();

    typedef logic [INPUT_BITS-1:0] comp_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] tag;
    } packed_rot_t;

    // expected packed rotations, oldest first
    class packed_rot_board;
        packed_rot_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // integer square root, floor
        function automatic logic [63:0] root_floor(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function automatic logic [7:0] map_byte(logic [63:0] mag, bit neg);
            logic [63:0] t;
            logic [63:0] q;
            t = 64'd11816942 * mag;
            if (!neg)
            begin
                q = t >> 31;
                return (q >= 127) ? 8'd255 : 8'(128 + q);
            end
            q = (t + 64'h7fff_ffff) >> 31;
            return (q >= 128) ? 8'd0 : 8'(128 - q);
        endfunction

        function automatic packed_rot_t pack_rotation(comp_t c[4]);
            logic [63:0] a[4];
            logic [63:0] n[4];
            bit sgn[4];
            logic [63:0] m;
            logic [63:0] sum;
            logic [63:0] len;
            logic [63:0] q;
            logic [7:0] bytes[3];
            int p;
            int big;
            int k;
            packed_rot_t res;
            m = 0;
            sum = 0;
            p = 0;
            big = 0;
            k = 0;
            for (int i = 0; i < 4; i++)
            begin
                sgn[i] = c[i][INPUT_BITS-1];
                a[i] = sgn[i] ? 64'(comp_t'(-c[i])) : 64'(c[i]);
                if (a[i] > m)
                    m = a[i];
            end
            if (m == 0)
                return {8'd128, 8'd128, 8'd128, TAG_BASE};
            while (p < 63 && (m >> (p + 1)) != 0)
                p++;
            for (int i = 0; i < 4; i++)
            begin
                a[i] = (p > 15) ? (a[i] >> (p - 15)) : (a[i] << (15 - p));
                sum += a[i] * a[i];
            end
            len = root_floor(sum << 28);
            for (int i = 0; i < 4; i++)
            begin
                q = ((a[i] << 29) + (len >> 1)) / len;
                n[i] = (q > 32767) ? 64'd32767 : q;
                if (n[i] > n[big])
                    big = i;
            end
            // flip so the dropped component is positive
            if (sgn[big])
                for (int i = 0; i < 4; i++)
                    sgn[i] = !sgn[i];
            for (int i = 0; i < 4; i++)
                if (i != big)
                begin
                    bytes[k] = map_byte(n[i], sgn[i]);
                    k++;
                end
            res.b0 = bytes[0];
            res.b1 = bytes[1];
            res.b2 = bytes[2];
            res.tag = TAG_BASE + 8'(big);
            return res;
        endfunction

        function void note_item(comp_t c[4]);
            pending = {pending, pack_rotation(c)};
        endfunction

        function void check_result(packed_rot_t got);
            packed_rot_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.b0 !== want.b0)
                $display("%0t: byte_first expected %0d actual %0d", $time, want.b0, got.b0);
            if (got.b1 !== want.b1)
                $display("%0t: byte_second expected %0d actual %0d", $time, want.b1, got.b1);
            if (got.b2 !== want.b2)
                $display("%0t: byte_third expected %0d actual %0d", $time, want.b2, got.b2);
            if (got.tag !== want.tag)
                $display("%0t: tag_byte expected %0d actual %0d", $time, want.tag, got.tag);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    comp_t comp_zero, comp_one, comp_two, comp_three;
    logic done;
    logic [7:0] byte_first, byte_second, byte_third, tag_byte;

    packed_rot_board board;

    quaternion_smallest_three_packer_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .comp_zero(comp_zero), .comp_one(comp_one),
        .comp_two(comp_two), .comp_three(comp_three),
        .done(done), .byte_first(byte_first), .byte_second(byte_second),
        .byte_third(byte_third), .tag_byte(tag_byte)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // result sampling
    always @(posedge clk)
        if (rst_n && done)
            board.check_result({byte_first, byte_second, byte_third, tag_byte});

    // random gap, mostly short
    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // present one item and hold it until accepted
    task automatic send_item(comp_t c0, comp_t c1, comp_t c2, comp_t c3);
        comp_t c[4];
        c = '{c0, c1, c2, c3};
        start <= 1'b1;
        comp_zero <= c0;
        comp_one <= c1;
        comp_two <= c2;
        comp_three <= c3;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(c);
    endtask

    // random component with wide spread of scales
    function automatic comp_t rand_comp();
        int sh;
        sh = $urandom_range(0, 15);
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return comp_t'($urandom()) >>> sh;
        endcase
    endfunction

    initial
    begin
        int waited;
        board = new();
        rst_n = 0;
        start = 0;
        comp_zero = 0;
        comp_one = 0;
        comp_two = 0;
        comp_three = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, extremes, ties, sign flips, indices 0 to 2 each largest
        send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'h0000, 16'h8000, 16'h0000, 16'h0001);
        send_item(16'h0000, 16'h0000, 16'h7fff, 16'hffff);
        send_item(16'h0001, 16'h0000, 16'h0000, 16'hffff);
        send_item(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_item(16'hffff, 16'h0001, 16'hffff, 16'h0001);
        send_item(16'h4000, 16'hc000, 16'h4000, 16'hc000);
        send_item(16'hb505, 16'h4afb, 16'h0000, 16'h0000);
        send_item(16'h7fff, 16'h8000, 16'h0000, 16'h0000);
        send_item(16'h8000, 16'h7fff, 16'h8001, 16'h0000);
        send_item(16'h1000, 16'hf000, 16'h2000, 16'he000);
        send_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        idle_gap();

        // random part, with a back-to-back run in the middle
        for (int i = 0; i < 1550; i++)
        begin
            send_item(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            if (i < 600 || i > 800)
                idle_gap();
        end
        start <= 1'b0;

        // drain
        waited = 0;
        while (board.pending.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
